FILE: hw/rtl/keyed_count_table_core_assert.svh
// Assertion macros shared by the table core. Each one checks a property on the
// rising clock edge and is switched off while reset is asserted.
`ifndef KEYED_COUNT_TABLE_CORE_ASSERT_SVH
`define KEYED_COUNT_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/kct_pkg.sv
package kct_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_LIST   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_CMP,
        S_FOUND,
        S_LFETCH,
        S_LDATA,
        S_EMIT
    } kct_state_t;

    typedef struct packed {
        action_t            action;
        logic signed [31:0] part_key;
        logic signed [31:0] amount;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] out_key;
        logic signed [31:0] out_count;
        logic               last;
    } out_item_t;

    localparam logic signed [31:0] COUNT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COUNT_MIN = 32'sh8000_0000;

endpackage

FILE: hw/rtl/kct_req_if.sv
interface kct_req_if;
    import kct_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/kct_rsp_if.sv
interface kct_rsp_if;
    import kct_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/keyed_count_table_core.sv
// Keyed count table with insert, search, saturating update and sorted listing.
// One request is taken at a time; ready is high only while the sequencer is idle,
// and a finished result waits in an output register while the next request is
// taken. Keys and counts sit in a single-read-port memory that is scanned one
// entry at a time (address in S_READ, then registered compare in S_CMP). Insert,
// search and update scan until a match or the end of the table. List runs one
// full minimum scan per emitted entry, and an empty table answers without a
// scan. No clearing pass follows reset.
module keyed_count_table_core #(
    parameter int CAPACITY = 64
) (
    input logic       clk,
    input logic       rst_n,
    kct_req_if.sink   req,
    kct_rsp_if.source rsp
);
    import kct_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] key_mem   [CAPACITY];
    logic signed [31:0] count_mem [CAPACITY];
    logic signed [31:0] key_rd_reg;
    logic signed [31:0] count_rd_reg;

    kct_state_t         state_reg, state_next;
    in_item_t           cmd_reg, cmd_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      emit_cnt_reg, emit_cnt_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic signed [31:0] best_key_reg, best_key_next;
    logic signed [31:0] prev_key_reg, prev_key_next;
    logic               have_best_reg, have_best_next;
    logic               have_prev_reg, have_prev_next;
    out_item_t          res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic               key_we;
    logic               cnt_we;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_key;
    logic signed [31:0] wr_count;

    logic               key_hit;
    logic               scan_end;
    logic               cand;
    logic               count_full;
    logic               out_free;
    logic               list_more;
    logic               do_miss;
    logic [32:0]        sum_wide;
    logic signed [31:0] sum_sat;

    assign key_hit    = key_rd_reg == cmd_reg.part_key;
    assign scan_end   = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign cand       = (!have_prev_reg || key_rd_reg > prev_key_reg)
                        && (!have_best_reg || key_rd_reg < best_key_reg);
    assign count_full = count_reg == CW'(CAPACITY);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign list_more  = (cmd_reg.action == ACT_LIST) && !res_reg.last;

    assign sum_wide = {count_rd_reg[31], count_rd_reg} + {cmd_reg.amount[31], cmd_reg.amount};
    assign sum_sat  = (sum_wide[32] != sum_wide[31])
                      ? (sum_wide[32] ? COUNT_MIN : COUNT_MAX)
                      : sum_wide[31:0];

    assign do_miss = (cmd_reg.action != ACT_LIST)
                     && (((state_reg == S_START) && (count_reg == '0)
                          && !((cmd_reg.action == ACT_INSERT) && count_full))
                         || ((state_reg == S_CMP) && !key_hit && scan_end));

    assign req.ready = state_reg == S_IDLE;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (cmd_reg.action == ACT_LIST)
                begin
                    state_next = (count_reg == '0) ? S_EMIT : S_READ;
                end
                else if ((cmd_reg.action == ACT_INSERT) && count_full)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = (count_reg == '0) ? S_EMIT : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (cmd_reg.action == ACT_LIST)
                begin
                    state_next = scan_end ? S_LFETCH : S_READ;
                end
                else if (key_hit)
                begin
                    state_next = S_FOUND;
                end
                else
                begin
                    state_next = scan_end ? S_EMIT : S_READ;
                end
            end
            S_FOUND:
            begin
                state_next = S_EMIT;
            end
            S_LFETCH:
            begin
                state_next = S_LDATA;
            end
            S_LDATA:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = list_more ? S_READ : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        emit_cnt_next  = emit_cnt_reg;
        idx_next       = idx_reg;
        best_idx_next  = best_idx_reg;
        best_key_next  = best_key_reg;
        prev_key_next  = prev_key_reg;
        have_best_next = have_best_reg;
        have_prev_next = have_prev_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        key_we         = 1'b0;
        cnt_we         = 1'b0;
        wr_addr        = idx_reg;
        wr_key         = cmd_reg.part_key;
        wr_count       = sum_sat;

        if (do_miss)
        begin
            if (cmd_reg.action == ACT_INSERT)
            begin
                key_we     = 1'b1;
                cnt_we     = 1'b1;
                wr_addr    = count_reg[AW-1:0];
                wr_count   = cmd_reg.amount;
                count_next = count_reg + CW'(1);
                res_next   = '{ST_OK, cmd_reg.part_key, cmd_reg.amount, 1'b1};
            end
            else
            begin
                res_next = '{ST_NOT_FOUND, cmd_reg.part_key, 32'sd0, 1'b1};
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next       = req.data;
                    emit_cnt_next  = '0;
                    idx_next       = '0;
                    have_best_next = 1'b0;
                    have_prev_next = 1'b0;
                end
            end
            S_START:
            begin
                if ((cmd_reg.action == ACT_LIST) && (count_reg == '0))
                begin
                    res_next = '{ST_EMPTY, 32'sd0, 32'sd0, 1'b1};
                end
                else if ((cmd_reg.action == ACT_INSERT) && count_full)
                begin
                    res_next = '{ST_FULL, cmd_reg.part_key, 32'sd0, 1'b1};
                end
            end
            S_CMP:
            begin
                if (cmd_reg.action == ACT_LIST)
                begin
                    if (cand)
                    begin
                        best_key_next  = key_rd_reg;
                        best_idx_next  = idx_reg;
                        have_best_next = 1'b1;
                    end
                    if (scan_end)
                    begin
                        idx_next = cand ? idx_reg : best_idx_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else if (!key_hit && !scan_end)
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_FOUND:
            begin
                case (cmd_reg.action)
                    ACT_INSERT:
                    begin
                        res_next = '{ST_DUPLICATE, cmd_reg.part_key, count_rd_reg, 1'b1};
                    end
                    ACT_UPDATE:
                    begin
                        cnt_we   = 1'b1;
                        res_next = '{ST_OK, cmd_reg.part_key, sum_sat, 1'b1};
                    end
                    default:
                    begin
                        res_next = '{ST_OK, cmd_reg.part_key, count_rd_reg, 1'b1};
                    end
                endcase
            end
            S_LDATA:
            begin
                res_next = '{ST_OK, key_rd_reg, count_rd_reg,
                             (emit_cnt_reg + CW'(1)) == count_reg};
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    if (list_more)
                    begin
                        prev_key_next  = res_reg.out_key;
                        have_prev_next = 1'b1;
                        have_best_next = 1'b0;
                        emit_cnt_next  = emit_cnt_reg + CW'(1);
                        idx_next       = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            emit_cnt_reg  <= '0;
            idx_reg       <= '0;
            have_best_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            emit_cnt_reg  <= emit_cnt_next;
            idx_reg       <= idx_next;
            have_best_reg <= have_best_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        prev_key_reg <= prev_key_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (cnt_we)
        begin
            count_mem[wr_addr] <= wr_count;
        end
        key_rd_reg   <= key_mem[idx_reg];
        count_rd_reg <= count_mem[idx_reg];
    end

`include "keyed_count_table_core_assert.svh"

    `KCT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `KCT_ASSERT_NEXT(a_accept_start, req.valid && req.ready, state_reg == S_START, "request not started")
    `KCT_ASSERT_NOW(a_full_status, rsp.valid && rsp.data.status == ST_FULL, count_full, "full reported early")

endmodule

FILE: bench/kct_checker.sv
module kct_checker #(
    parameter int CAPACITY = 64
) (
    input  logic clk,
    input  logic rst_n,
    kct_req_if   req,
    kct_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   results_checked
);
    import kct_pkg::*;

    localparam int REPORT_LIMIT = 40;

    logic signed [31:0] tbl_key   [CAPACITY];
    logic signed [31:0] tbl_count [CAPACITY];
    int                 tbl_used;
    out_item_t          expected_q [$];
    int                 errors;
    int                 checked;
    int                 reports;

    function automatic int find_key(logic signed [31:0] k);
        for (int i = 0; i < tbl_used; i++)
        begin
            if (tbl_key[i] == k)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic out_item_t make_result(status_t st, logic signed [31:0] k,
                                              logic signed [31:0] c, logic l);
        out_item_t r;
        r.status    = st;
        r.out_key   = k;
        r.out_count = c;
        r.last      = l;
        return r;
    endfunction

    function automatic void predict_request(in_item_t r);
        int     idx;
        int     j;
        longint sum;
        int     order [CAPACITY];
        case (r.action)
            ACT_INSERT:
            begin
                if (tbl_used >= CAPACITY)
                begin
                    expected_q.push_back(make_result(ST_FULL, r.part_key, '0, 1'b1));
                end
                else
                begin
                    idx = find_key(r.part_key);
                    if (idx >= 0)
                    begin
                        expected_q.push_back(make_result(ST_DUPLICATE, r.part_key,
                                                         tbl_count[idx], 1'b1));
                    end
                    else
                    begin
                        tbl_key[tbl_used]   = r.part_key;
                        tbl_count[tbl_used] = r.amount;
                        tbl_used++;
                        expected_q.push_back(make_result(ST_OK, r.part_key, r.amount, 1'b1));
                    end
                end
            end
            ACT_SEARCH, ACT_UPDATE:
            begin
                idx = find_key(r.part_key);
                if (idx < 0)
                begin
                    expected_q.push_back(make_result(ST_NOT_FOUND, r.part_key, '0, 1'b1));
                end
                else
                begin
                    if (r.action == ACT_UPDATE)
                    begin
                        sum = longint'(tbl_count[idx]) + longint'(r.amount);
                        if (sum > longint'(COUNT_MAX))
                        begin
                            sum = longint'(COUNT_MAX);
                        end
                        if (sum < longint'(COUNT_MIN))
                        begin
                            sum = longint'(COUNT_MIN);
                        end
                        tbl_count[idx] = sum[31:0];
                    end
                    expected_q.push_back(make_result(ST_OK, r.part_key, tbl_count[idx], 1'b1));
                end
            end
            default:
            begin
                if (tbl_used == 0)
                begin
                    expected_q.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
                end
                else
                begin
                    // Entries are listed by ascending signed key; the stored order stays.
                    for (int i = 0; i < tbl_used; i++)
                    begin
                        j = i;
                        while (j > 0 && tbl_key[order[j - 1]] > tbl_key[i])
                        begin
                            order[j] = order[j - 1];
                            j--;
                        end
                        order[j] = i;
                    end
                    for (int i = 0; i < tbl_used; i++)
                    begin
                        expected_q.push_back(make_result(ST_OK, tbl_key[order[i]],
                                                         tbl_count[order[i]],
                                                         i == tbl_used - 1));
                    end
                end
            end
        endcase
    endfunction

    function automatic bit field_ok(string name, logic signed [31:0] want_v,
                                    logic signed [31:0] got_v);
        if (got_v === want_v)
        begin
            return 1'b1;
        end
        if (reports < REPORT_LIMIT)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        end
        reports++;
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        bit        ok;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                checked++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (reports < REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result, expected none, actual status %0d key %0d count %0d last %0b",
                                 $time, rsp.data.status, rsp.data.out_key,
                                 rsp.data.out_count, rsp.data.last);
                    end
                    reports++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    ok = field_ok("status", want.status, rsp.data.status)
                       & field_ok("out_key", want.out_key, rsp.data.out_key)
                       & field_ok("out_count", want.out_count, rsp.data.out_count)
                       & field_ok("last", want.last, rsp.data.last);
                    if (!ok)
                    begin
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                predict_request(req.data);
            end
        end
        fail_count      <= errors;
        pending         <= expected_q.size();
        results_checked <= checked;
    end

endmodule

FILE: bench/tb_top.sv
module tb_top;
    import kct_pkg::*;

    localparam int CAPACITY = 64;

    logic               clk = 1'b0;
    logic               rst_n;
    int                 fail_count;
    int                 pending;
    int                 results_checked;
    bit                 quiet;
    int                 sent;
    int                 stall_left;
    int                 act_sent [4];
    logic signed [31:0] key_pool [$];

    kct_req_if req ();
    kct_rsp_if rsp ();

    keyed_count_table_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    kct_checker #(
        .CAPACITY(CAPACITY)
    ) table_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] edge_value();
        case ($urandom_range(0, 5))
            0:       return COUNT_MAX;
            1:       return COUNT_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return COUNT_MAX - 32'sd1;
            default: return COUNT_MIN + 32'sd1;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && key_pool.size() > 0)
        begin
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        if (r < 80)
        begin
            return $urandom;
        end
        if (r < 90)
        begin
            return $urandom_range(0, 16) - 8;
        end
        return edge_value();
    endfunction

    function automatic logic signed [31:0] pick_amount();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return $urandom;
        end
        if (r < 85)
        begin
            return $urandom_range(0, 200) - 100;
        end
        return edge_value();
    endfunction

    function automatic action_t pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 34)
        begin
            return ACT_INSERT;
        end
        if (r < 60)
        begin
            return ACT_SEARCH;
        end
        if (r < 92)
        begin
            return ACT_UPDATE;
        end
        return ACT_LIST;
    endfunction

    task automatic send_request(input action_t act, input logic signed [31:0] k,
                                input logic signed [31:0] a);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.data  <= '{action: act, part_key: k, amount: a};
        req.valid <= 1'b1;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        act_sent[act]++;
        if (act == ACT_INSERT)
        begin
            key_pool.push_back(k);
        end
        sent++;
        quiet = ((sent / 30) % 3) == 2;
    endtask

    task automatic run_mix(input int n);
        repeat (n) send_request(pick_action(), pick_key(), pick_amount());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                rsp.ready <= (stall_left == 0);
                if (stall_left > 0)
                begin
                    stall_left--;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req.valid <= 1'b0;
        req.data  <= '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(ACT_LIST, -32'sd1, COUNT_MAX);
        send_request(ACT_SEARCH, 32'sd5, 32'sd9);
        send_request(ACT_UPDATE, COUNT_MIN, 32'sd3);
        send_request(ACT_INSERT, COUNT_MAX, COUNT_MAX);
        send_request(ACT_INSERT, COUNT_MIN, COUNT_MIN);
        send_request(ACT_INSERT, 32'sd0, 32'sd0);
        send_request(ACT_INSERT, -32'sd1, -32'sd1);
        send_request(ACT_INSERT, COUNT_MAX, 32'sd7);
        send_request(ACT_UPDATE, COUNT_MAX, COUNT_MAX);
        send_request(ACT_UPDATE, COUNT_MIN, COUNT_MIN);
        send_request(ACT_UPDATE, 32'sd0, COUNT_MIN);
        send_request(ACT_UPDATE, -32'sd1, 32'sd1);
        send_request(ACT_SEARCH, -32'sd1, -32'sd1);
        send_request(ACT_UPDATE, COUNT_MAX, COUNT_MIN);
        send_request(ACT_LIST, 32'sh1234_5678, -32'sd77);

        run_mix(110);
        wait_drained();

        // Fill the table well past capacity, then hit it with known keys while full.
        repeat (70) send_request(ACT_INSERT, $urandom, pick_amount());
        repeat (4) send_request(ACT_INSERT, key_pool[$urandom_range(0, key_pool.size() - 1)],
                                pick_amount());
        send_request(ACT_LIST, $urandom, $urandom);

        run_mix(120);
        wait_drained();
        repeat (300) @(negedge clk);

        $display("Sent %0d requests: %0d insert, %0d search, %0d update, %0d list.",
                 sent, act_sent[ACT_INSERT], act_sent[ACT_SEARCH], act_sent[ACT_UPDATE],
                 act_sent[ACT_LIST]);
        $display("Checked %0d results, including listings of an empty and a full table.",
                 results_checked);
        if (fail_count == 0 && pending == 0)
        begin
            $display("[keyed_count_table_core] OK");
        end
        else
        begin
            $display("[keyed_count_table_core] ERROR");
        end
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("[keyed_count_table_core] ERROR");
        $finish;
    end

endmodule
